### rtl/pfmn_pkg.sv
// pfmn_pkg: shared widths, codes and types of the per-feature max normalizer
// depends on nothing; used by pfmn_div, the top and both bench files
`default_nettype none

package pfmn_pkg;

  localparam int VALUE_W          = 32;   // Q16.16 sample width
  localparam int FRAC_W           = 16;   // fraction bits of Q16.16
  localparam int COLUMN_W         = 6;    // column field on the result channel
  localparam int CFG_W            = 7;    // feature count register width
  localparam int DIV_NUM_W        = 48;   // dividend: 32-bit magnitude shifted by 16
  localparam int DIV_DEN_W        = 32;   // divisor: column maximum or feature count
  localparam int STEP_W           = 6;    // holds up to DIV_NUM_W divider steps
  localparam int DEF_MAX_VALUES   = 4096;
  localparam int DEF_MAX_FEATURES = 64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_W-1:0]   CFG_RESET = 7'd1;
  localparam logic [VALUE_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] SAT_MIN   = 32'h8000_0000;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/pfmn_ram.sv
// pfmn_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module pfmn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/pfmn_div.sv
// pfmn_div: radix-2 restoring divider, one quotient bit per cycle
// depends on pfmn_pkg (widths, divider control and status structs)
`default_nettype none

module pfmn_div #(
  parameter int NUM_W = pfmn_pkg::DIV_NUM_W,
  parameter int DEN_W = pfmn_pkg::DIV_DEN_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pfmn_pkg::div_ctrl_t  ctrl,
  input  wire logic [NUM_W-1:0]     num,
  input  wire logic [DEN_W-1:0]     den,
  output pfmn_pkg::div_stat_t       stat,
  output logic      [NUM_W-1:0]     quo,
  output logic      [DEN_W-1:0]     rem
);

  logic [DEN_W-1:0]            d;
  logic [pfmn_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [DEN_W:0]              trial;
  logic [DEN_W:0]              diff;

  // shift in the next dividend bit, subtract when it fits
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pfmn_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### rtl/per_feature_max_normalizer_top.sv
// per_feature_max_normalizer_top: max-abs feature scaling in Q16.16
// depends on pfmn_pkg, pfmn_ram (value store, column maxima), pfmn_div
//
// usage
//   in channel (in_valid/in_ready): operation selects a load of feature_value
//   or a drain of one normalized value. loads arrive in row order; a value's
//   column is its load position modulo feature_count (0 means 1, values above
//   MAX_FEATURES clamp). the first drain ends loading; later loads are dropped,
//   as are loads past MAX_VALUES and drains of an empty list
//   out channel (out_valid/out_ready): one transaction per accepted drain with
//   value * 2^16 / column max (truncated, saturated, zero when max is zero),
//   its column and last on the final value. after last the list clears
//   cfg channel (cfg_valid/cfg_ready, cfg_data): feature_count, always ready
//   timing: one item at a time, all work goes through a shared one-bit-per-
//   cycle divider. a load works out its column (S_MOD), reads the store and
//   maximum (S_RD) and updates the maximum (S_MAX); a drain works out its
//   column and reads likewise, then runs the scaling divide (S_DIV) and
//   passes the result on (S_PUT); one with zero column maximum skips the divide
//   stall: a finished result sits in the output register while the next item
//   is accepted; a second result waits in its last state until that register
//   is taken
//   reset: synchronous; list empty, maxima read as zero, feature_count 1.
//   the value store is not cleared, only entries of the current list are read
`default_nettype none

module per_feature_max_normalizer_top #(
  parameter int MAX_VALUES   = pfmn_pkg::DEF_MAX_VALUES,
  parameter int MAX_FEATURES = pfmn_pkg::DEF_MAX_FEATURES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pfmn_pkg::CFG_W-1:0]         cfg_data,
  // input transactions
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               operation,
  input  wire logic signed [pfmn_pkg::VALUE_W-1:0] feature_value,
  // result transactions
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [pfmn_pkg::VALUE_W-1:0]     normalized_value,
  output logic        [pfmn_pkg::COLUMN_W-1:0]    column,
  output logic                                    last
);

  localparam int VALUE_W   = pfmn_pkg::VALUE_W;
  localparam int DIV_NUM_W = pfmn_pkg::DIV_NUM_W;
  localparam int DIV_DEN_W = pfmn_pkg::DIV_DEN_W;
  localparam int COLUMN_W  = pfmn_pkg::COLUMN_W;
  localparam int CNT_W     = $clog2(MAX_VALUES + 1);
  localparam int SA_W      = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int FA_W      = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // waiting for a transaction
    S_MOD  = 6'b000010,  // divider works out the column
    S_RD   = 6'b000100,  // memories read at column / list index
    S_MAX  = 6'b001000,  // update maximum (load), start or skip the divide (drain)
    S_DIV  = 6'b010000,  // scaling divide in progress
    S_PUT  = 6'b100000   // result waits for the output register
  } state_t;

  state_t state;

  // list state
  logic [pfmn_pkg::CFG_W-1:0] feature_count;
  logic [CNT_W-1:0]           loaded_count;
  logic [CNT_W-1:0]           drain_pointer;
  logic                       draining;
  logic [MAX_FEATURES-1:0]    cval;        // column maximum written this list

  // per-item registers
  logic [CNT_W-1:0]    idx;
  logic                is_drain;
  logic                is_last;
  logic                zero_res;
  logic [FA_W-1:0]     col;
  logic [COLUMN_W-1:0] col_tag;
  logic [VALUE_W-1:0]  val;

  // memories
  logic [VALUE_W-1:0] store_rdata;
  logic [VALUE_W-1:0] cmax_rdata;
  logic               cmax_we;

  // divider
  pfmn_pkg::div_ctrl_t div_ctrl;
  pfmn_pkg::div_stat_t div_stat;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  logic                 in_fire;
  logic                 load_ok;
  logic                 drain_ok;
  logic [CNT_W-1:0]     idx_sel;
  logic [DIV_DEN_W-1:0] fc_ext;
  logic [DIV_DEN_W-1:0] nf;
  logic [VALUE_W-1:0]   cmax_cur;
  logic                 m_zero;
  logic [VALUE_W-1:0]   mag;
  logic                 pos_over;
  logic                 neg_over;
  logic [VALUE_W-1:0]   res;
  logic                 put_fire;

  // configuration is taken in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count <= pfmn_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      feature_count <= cfg_data;
    end
  end

  // effective feature count: zero acts as one, large values clamp
  assign fc_ext = DIV_DEN_W'(feature_count);
  assign nf = (feature_count == '0)                   ? DIV_DEN_W'(1) :
              (fc_ext > DIV_DEN_W'(MAX_FEATURES))      ? DIV_DEN_W'(MAX_FEATURES) :
              fc_ext;

  // input acceptance and filtering of ignored transactions
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_ok  = in_fire && (operation == pfmn_pkg::OP_LOAD) && !draining &&
                    (loaded_count < CNT_W'(MAX_VALUES));
  assign drain_ok = in_fire && (operation == pfmn_pkg::OP_DRAIN) &&
                    (loaded_count != '0) && (drain_pointer < loaded_count);
  assign idx_sel  = (operation == pfmn_pkg::OP_DRAIN) ? drain_pointer : loaded_count;

  // maximum of the current column, zero until written in this list
  assign cmax_cur = cval[col] ? cmax_rdata : '0;
  assign m_zero   = (cmax_cur == '0) || cmax_cur[VALUE_W-1];
  assign mag      = store_rdata[VALUE_W-1] ? (~store_rdata + 1'b1) : store_rdata;

  // shared divider: list index mod feature count, then |value| * 2^16 / max.
  // the index is aligned to the top of the dividend so CNT_W steps suffice
  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.steps = pfmn_pkg::STEP_W'(CNT_W);
    div_num        = {idx_sel, {(DIV_NUM_W - CNT_W){1'b0}}};
    div_den        = nf;
    if (state == S_IDLE) begin
      div_ctrl.start = load_ok || drain_ok;
    end else begin
      div_ctrl.start = (state == S_MAX) && is_drain && !m_zero;
      div_ctrl.steps = pfmn_pkg::STEP_W'(DIV_NUM_W);
      div_num        = DIV_NUM_W'(mag) << pfmn_pkg::FRAC_W;
      div_den        = cmax_cur;
    end
  end

  pfmn_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .num  (div_num),
    .den  (div_den),
    .stat (div_stat),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // value store: written at load accept, read at the latched list index
  pfmn_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_VALUES)
  ) u_store (
    .clk   (clk),
    .we    (load_ok),
    .waddr (loaded_count[SA_W-1:0]),
    .wdata (feature_value),
    .raddr (idx[SA_W-1:0]),
    .rdata (store_rdata)
  );

  // column maxima: read-modify-write, one item in flight so no overlap
  assign cmax_we = (state == S_MAX) && !is_drain && ($signed(val) > $signed(cmax_cur));

  pfmn_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_FEATURES)
  ) u_cmax (
    .clk   (clk),
    .we    (cmax_we),
    .waddr (col),
    .wdata (val),
    .raddr (col),
    .rdata (cmax_rdata)
  );

  // saturate the quotient magnitude and restore the sign
  assign pos_over = |div_quo[DIV_NUM_W-1:VALUE_W-1];
  assign neg_over = (|div_quo[DIV_NUM_W-1:VALUE_W]) ||
                    (div_quo[VALUE_W-1] && (|div_quo[VALUE_W-2:0]));

  always_comb begin
    if (zero_res) begin
      res = '0;
    end else if (val[VALUE_W-1]) begin
      res = neg_over ? pfmn_pkg::SAT_MIN : (~div_quo[VALUE_W-1:0] + 1'b1);
    end else begin
      res = pos_over ? pfmn_pkg::SAT_MAX : div_quo[VALUE_W-1:0];
    end
  end

  assign put_fire = (state == S_PUT) && (!out_valid || out_ready);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      loaded_count  <= '0;
      drain_pointer <= '0;
      draining      <= 1'b0;
      cval          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (put_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load_ok || drain_ok) begin
            state <= S_MOD;
          end
          if (drain_ok) begin
            draining <= 1'b1;
          end
        end
        S_MOD: begin
          if (div_stat.done) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_MAX;
        end
        S_MAX: begin
          if (!is_drain) begin
            if (cmax_we) begin
              cval[col] <= 1'b1;
            end
            loaded_count <= loaded_count + 1'b1;
            state        <= S_IDLE;
          end else if (m_zero) begin
            state <= S_PUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_fire) begin
            state <= S_IDLE;
            if (is_last) begin
              loaded_count  <= '0;
              drain_pointer <= '0;
              draining      <= 1'b0;
              cval          <= '0;
            end else begin
              drain_pointer <= drain_pointer + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    if (load_ok || drain_ok) begin
      idx      <= idx_sel;
      is_drain <= drain_ok;
      is_last  <= (drain_pointer + CNT_W'(1)) == loaded_count;
    end
    if (load_ok) begin
      val <= feature_value;
    end
    if ((state == S_MOD) && div_stat.done) begin
      col     <= div_rem[FA_W-1:0];
      col_tag <= div_rem[COLUMN_W-1:0];
    end
    if ((state == S_MAX) && is_drain) begin
      val      <= store_rdata;
      zero_res <= m_zero;
    end
    if (put_fire) begin
      normalized_value <= res;
      column           <= col_tag;
      last             <= is_last;
    end
  end

  // the shared divider is never restarted under a new transaction
  assert property (@(posedge clk) disable iff (rst) div_stat.busy |-> !in_ready)
    else $error("input accepted while the divider is busy");

  // a final drain leaves an empty list behind
  assert property (@(posedge clk) disable iff (rst)
    (put_fire && is_last) |=> (loaded_count == '0 && !draining && cval == '0))
    else $error("list not cleared after the last drain");

  // while draining the pointer stays inside the loaded list
  assert property (@(posedge clk) disable iff (rst) draining |-> (drain_pointer < loaded_count))
    else $error("drain pointer beyond loaded values");

  // the store never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) loaded_count <= CNT_W'(MAX_VALUES))
    else $error("loaded count past capacity");

endmodule

`default_nettype wire

### bench/normalizer_checker.sv
`timescale 1ns / 100ps
// normalizer_checker: watches the cfg, in and out channels of the max-abs normalizer,
// mirrors its list state, predicts every drained value and compares each out transaction
// depends on pfmn_pkg

module normalizer_checker #(
  parameter int MAX_VALUES   = pfmn_pkg::DEF_MAX_VALUES,
  parameter int MAX_FEATURES = pfmn_pkg::DEF_MAX_FEATURES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic        [pfmn_pkg::CFG_W-1:0]     cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  operation,
  input  logic signed [pfmn_pkg::VALUE_W-1:0]   feature_value,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [pfmn_pkg::VALUE_W-1:0]   normalized_value,
  input  logic        [pfmn_pkg::COLUMN_W-1:0]  column,
  input  logic                                  last,
  output int                                    mismatch_count,
  output int                                    outstanding
);

  localparam int     VALUE_W  = pfmn_pkg::VALUE_W;
  localparam int     COLUMN_W = pfmn_pkg::COLUMN_W;
  localparam int     CFG_W    = pfmn_pkg::CFG_W;
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic        [COLUMN_W-1:0] col;
    logic                       is_last;
  } scaled_t;

  scaled_t                   pending_scaled[$];
  logic signed [VALUE_W-1:0] stored_value [MAX_VALUES];
  logic signed [VALUE_W-1:0] col_max [MAX_FEATURES];
  int unsigned               loaded_count;
  int unsigned               drain_ptr;
  bit                        draining;
  logic [CFG_W-1:0]          feature_count;

  initial mismatch_count = 0;
  initial outstanding = 0;

  function automatic int unsigned active_columns(logic [CFG_W-1:0] fc);
    if (fc == 0) return 1;
    if (fc > MAX_FEATURES) return MAX_FEATURES;
    return fc;
  endfunction

  // value * 2^16 / max, truncated toward zero, saturated, zero for an empty maximum
  function automatic logic signed [VALUE_W-1:0] max_abs_scale(logic signed [VALUE_W-1:0] v,
                                                              logic signed [VALUE_W-1:0] m);
    longint q;
    if (m <= 0) return '0;
    q = (longint'(v) * 65536) / longint'(m);
    if (q > Q_HI) return pfmn_pkg::SAT_MAX;
    if (q < Q_LO) return pfmn_pkg::SAT_MIN;
    return q[VALUE_W-1:0];
  endfunction

  task automatic clear_list();
    foreach (col_max[i]) col_max[i] = '0;
    loaded_count = 0;
    drain_ptr = 0;
    draining = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < 100)
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    scaled_t     want;
    int unsigned nf;
    int unsigned col;
    if (rst) begin
      clear_list();
      feature_count = pfmn_pkg::CFG_RESET;
      pending_scaled.delete();
    end else begin
      if (cfg_valid && cfg_ready) feature_count = cfg_data;
      nf = active_columns(feature_count);
      if (in_valid && in_ready) begin
        if (operation == pfmn_pkg::OP_LOAD) begin
          if (!draining && loaded_count < MAX_VALUES) begin
            col = loaded_count % nf;
            stored_value[loaded_count] = feature_value;
            if (feature_value > col_max[col]) col_max[col] = feature_value;
            loaded_count++;
          end
        end else if (loaded_count != 0 && drain_ptr < loaded_count) begin
          draining = 1;
          col = drain_ptr % nf;
          want.value = max_abs_scale(stored_value[drain_ptr], col_max[col]);
          want.col = col[COLUMN_W-1:0];
          want.is_last = (drain_ptr + 1 == loaded_count);
          pending_scaled = {pending_scaled, want};
          if (want.is_last) clear_list();
          else drain_ptr++;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_scaled.size() == 0) begin
          report_mismatch("result with nothing pending, value", normalized_value, 0);
        end else begin
          want = pending_scaled.pop_front();
          if (normalized_value !== want.value)
            report_mismatch("normalized_value", normalized_value, want.value);
          if (column !== want.col)
            report_mismatch("column", column, want.col);
          if (last !== want.is_last)
            report_mismatch("last", last, want.is_last);
        end
      end
    end
    outstanding <= pending_scaled.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for per_feature_max_normalizer_top
// depends on pfmn_pkg, the block under rtl and normalizer_checker

module tb;

  localparam int     VALUE_W       = pfmn_pkg::VALUE_W;
  localparam int     COLUMN_W      = pfmn_pkg::COLUMN_W;
  localparam int     CFG_W         = pfmn_pkg::CFG_W;
  localparam int     MAX_VALUES    = pfmn_pkg::DEF_MAX_VALUES;
  localparam int     MAX_FEATURES  = pfmn_pkg::DEF_MAX_FEATURES;
  localparam int     RANDOM_ITEMS  = 1700;
  localparam int     CLOSING_ITEMS = 100;
  // long enough to cover any load or drain still in flight
  localparam int     SETTLE_CYCLES = 100;
  // roughly 2k items plus settling, taken several times over
  localparam longint CYCLE_LIMIT   = 1_000_000;

  logic                         clk           = 1'b0;
  logic                         rst           = 1'b1;
  logic                         cfg_valid     = 1'b0;
  logic        [CFG_W-1:0]      cfg_data      = pfmn_pkg::CFG_RESET;
  logic                         in_valid      = 1'b0;
  logic                         operation     = pfmn_pkg::OP_LOAD;
  logic signed [VALUE_W-1:0]    feature_value = '0;
  logic                         out_ready     = 1'b1;
  logic                         cfg_ready;
  logic                         in_ready;
  logic                         out_valid;
  logic signed [VALUE_W-1:0]    normalized_value;
  logic        [COLUMN_W-1:0]   column;
  logic                         last;

  int     mismatch_count;
  int     outstanding;
  int     idle_odds   = 0;   // 0 means no idling on either side
  int     out_stall   = 0;
  int     items_sent  = 0;
  longint cycle_count = 0;

  per_feature_max_normalizer_top #(
    .MAX_VALUES   (MAX_VALUES),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .feature_value    (feature_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .normalized_value (normalized_value),
    .column           (column),
    .last             (last)
  );

  normalizer_checker #(
    .MAX_VALUES   (MAX_VALUES),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .feature_value    (feature_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .normalized_value (normalized_value),
    .column           (column),
    .last             (last),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding)
  );

  always #1 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts
  always @(posedge clk) begin
    if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_ready <= 1'b0;
      out_stall <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // full-range words, small signed values, corners, negatives and shifted positives
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        v = $urandom_range(0, 262143);
        v = v - 131072;
      end
      6: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'h0000_0001;
          4:       v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      7:       v = {1'b1, 31'($urandom)};
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  // zero reads as one column, anything above the maximum clamps
  function automatic logic [CFG_W-1:0] pick_feature_count();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd1;
      3:       return 7'd64;
      4:       return 7'($urandom_range(65, 126));
      default: return 7'($urandom_range(2, 63));
    endcase
  endfunction

  // one in transaction; called in the time step of a rising edge
  task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] v);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    feature_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every result has been taken and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_feature_count(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one well-formed list with random content, plus occasional noise:
  // drains of an empty store, loads while draining, feature count changes mid-list
  task automatic run_list();
    int n;
    int k;
    case ($urandom_range(0, 2))
      0:       idle_odds <= 0;
      1:       idle_odds <= 3;
      default: idle_odds <= 8;
    endcase
    settle();
    if ($urandom_range(0, 1) == 0) write_feature_count(pick_feature_count());
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 24);
    if ($urandom_range(0, 7) == 0) send_item(pfmn_pkg::OP_DRAIN, pick_value());
    for (k = 0; k < n; k++) begin
      send_item(pfmn_pkg::OP_LOAD, pick_value());
      if (k == n / 2 && $urandom_range(0, 7) == 0) begin
        settle();
        write_feature_count(pick_feature_count());
      end
    end
    for (k = 0; k < n; k++) begin
      send_item(pfmn_pkg::OP_DRAIN, pick_value());
      // the list is still being drained here, so the load must be dropped
      if (k < n - 1 && $urandom_range(0, 19) == 0) send_item(pfmn_pkg::OP_LOAD, pick_value());
      if (k == n / 2 && k < n - 1 && $urandom_range(0, 9) == 0) begin
        settle();
        write_feature_count(pick_feature_count());
      end
    end
    if ($urandom_range(0, 5) == 0) send_item(pfmn_pkg::OP_DRAIN, pick_value());
    items_sent += 2 * n;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // drain with nothing loaded: no transaction comes back
    send_item(pfmn_pkg::OP_DRAIN, 32'h1234_5678);
    settle();

    // three columns with the field extremes; col 1 ends with a zero maximum
    write_feature_count(7'd3);
    send_item(pfmn_pkg::OP_LOAD, 32'h7FFF_FFFF);
    send_item(pfmn_pkg::OP_LOAD, 32'h8000_0000);
    send_item(pfmn_pkg::OP_LOAD, 32'h0000_0001);
    send_item(pfmn_pkg::OP_LOAD, 32'hFFFF_FFFF);
    send_item(pfmn_pkg::OP_LOAD, 32'h0000_0000);
    send_item(pfmn_pkg::OP_LOAD, 32'h0001_0000);
    send_item(pfmn_pkg::OP_DRAIN, 32'h0);
    // first drain closed the list, this load is dropped
    send_item(pfmn_pkg::OP_LOAD, 32'h55AA_55AA);
    repeat (5) send_item(pfmn_pkg::OP_DRAIN, 32'hFFFF_FFFF);
    settle();

    // load with two columns, drain with feature count zero (one column):
    // tiny maximum against huge values saturates both ways
    write_feature_count(7'd2);
    send_item(pfmn_pkg::OP_LOAD, 32'h0000_0001);
    send_item(pfmn_pkg::OP_LOAD, 32'h7FFF_FFFF);
    send_item(pfmn_pkg::OP_LOAD, 32'h8000_0000);
    settle();
    write_feature_count(7'd0);
    repeat (3) send_item(pfmn_pkg::OP_DRAIN, 32'h0);

    while (items_sent < RANDOM_ITEMS) run_list();

    // closing phase without idling: one more list loaded and drained back to back
    idle_odds <= 0;
    settle();
    write_feature_count(7'($urandom_range(1, 64)));
    repeat (CLOSING_ITEMS) send_item(pfmn_pkg::OP_LOAD, pick_value());
    repeat (CLOSING_ITEMS) send_item(pfmn_pkg::OP_DRAIN, pick_value());
    settle();

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pfmn_pkg.sv
rtl/pfmn_ram.sv
rtl/pfmn_div.sv
rtl/per_feature_max_normalizer_top.sv
bench/normalizer_checker.sv
bench/tb.sv
